// ----- src/a2pp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package a2pp_pkg;

    // Stream payload widths
    localparam int S_TDATA_W = 72;   // entry_index, entry_color, pixel_value
    localparam int M_TDATA_W = 40;   // output_word, byte_count, zero fill

    // Input item kinds, carried on tuser
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Configuration register indexes
    localparam logic CFG_OUT_FORMAT     = 1'b0;
    localparam logic CFG_SOURCE_INDEXED = 1'b1;

    // Display format codes; unused codes act as the 32-bit copy
    localparam logic [2:0] FMT_RGB555 = 3'd0;
    localparam logic [2:0] FMT_RGB565 = 3'd1;
    localparam logic [2:0] FMT_RGB24  = 3'd2;
    localparam logic [2:0] FMT_BGR24  = 3'd3;
    localparam logic [2:0] FMT_COPY32 = 3'd4;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

    // One accepted item as the pack stage holds it
    typedef struct packed {
        logic        cmd;
        logic [31:0] pixel_value;
        logic        end_of_line;
        logic        index_in_range;
    } item_t;

    // One result word
    typedef struct packed {
        logic [31:0] output_word;
        logic [2:0]  byte_count;
        logic        line_last;
    } result_t;

    // Words handed from the pack stage to the output queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// ----- src/argb_to_packed_pixel_stream_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pixel format converter. Each input transfer is either a palette load
// (tuser = 0), which writes entry_color into palette slot entry_index, or a
// pixel conversion (tuser = 1), which turns one ARGB pixel or palette index
// into RGB555, RGB565, 24-bit RGB, 24-bit BGR or a 32-bit copy, as set by the
// out_format register. The converted bytes are packed little-endian into
// 32-bit words, the first byte in bits 7..0; each output transfer carries the
// word and its count of valid bytes (unused bytes are zero). tlast on the input
// marks the end of a scan line: any leftover bytes are flushed as a partial
// word and tlast is set on the final word of the line. The block takes one
// item per clock cycle except while the input stalls. The input and the
// palette read are registered together; the pack stage then writes the
// four-word output queue. A conversion can yield two words in one cycle,
// so the input stalls only while the output queue holds more than two
// words, which happens only if the downstream side is slower than one word
// per cycle. The palette content is undefined after reset until written.
// The user must write configuration only while the block is idle; the block does not enforce it.
module argb_to_packed_pixel_stream_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] entry_index, [39:8] entry_color, [71:40] pixel_value
    input  wire logic [a2pp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                           s_axis_tlast,   // end_of_line
    input  wire logic                           s_axis_tuser,   // [0] cmd
    // Output stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] output_word, [34:32] byte_count, [39:35] zero
    output logic      [a2pp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                                m_axis_tlast,   // line_last
    // Configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [2:0]                     cfg_data
);

    import a2pp_pkg::*;

    localparam int         ADDR_W    = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] IDX_LIMIT = 9'(PALETTE_ENTRIES);

    logic [2:0]  out_format_reg;
    logic [2:0]  out_format_next;
    logic        source_indexed_reg;
    logic        source_indexed_next;

    logic        in_xfer;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
    logic [31:0] pixel_value;
    logic        entry_ok;
    item_t       in_item;
    logic        pal_wr;
    logic [31:0] pal_data;
    logic        out_space;
    push_t       push;
    result_t     head;

    // Configuration port: always ready, register write on transfer
    assign cfg_ready = 1'b1;

    always_comb
    begin
        out_format_next     = out_format_reg;
        source_indexed_next = source_indexed_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OUT_FORMAT:     out_format_next     = cfg_data;
                CFG_SOURCE_INDEXED: source_indexed_next = cfg_data[0];
                default:            out_format_next     = out_format_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_format_reg     <= FMT_COPY32;
            source_indexed_reg <= 1'b0;
        end
        else
        begin
            out_format_reg     <= out_format_next;
            source_indexed_reg <= source_indexed_next;
        end
    end

    // Unpack the input payload
    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign entry_index = s_axis_tdata[7:0];
    assign entry_color = s_axis_tdata[39:8];
    assign pixel_value = s_axis_tdata[71:40];

    // Slots at or beyond the palette size: drop loads, read as zero
    assign entry_ok = {1'b0, entry_index} < IDX_LIMIT;
    assign pal_wr   = in_xfer && (s_axis_tuser == CMD_LOAD) && entry_ok;

    always_comb
    begin
        in_item.cmd            = s_axis_tuser;
        in_item.pixel_value    = pixel_value;
        in_item.end_of_line    = s_axis_tlast;
        in_item.index_in_range = {1'b0, pixel_value[7:0]} < IDX_LIMIT;
    end

    a2pp_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_wr),
        .wr_addr (entry_index[ADDR_W-1:0]),
        .wr_data (entry_color),
        .rd_en   (in_xfer),
        .rd_addr (pixel_value[ADDR_W-1:0]),
        .rd_data (pal_data)
    );

    // Convert and pack; holds the pending bytes of the current line
    a2pp_pack u_pack (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_load        (in_xfer),
        .in_item        (in_item),
        .in_ready       (s_axis_tready),
        .palette_data   (pal_data),
        .out_format     (out_format_reg),
        .source_indexed (source_indexed_reg),
        .out_space      (out_space),
        .push           (push)
    );

    // Output queue parts the pack stage from the downstream side
    a2pp_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (out_space),
        .valid (m_axis_tvalid),
        .ready (m_axis_tready),
        .head  (head)
    );

    assign m_axis_tdata = {5'd0, head.byte_count, head.output_word};
    assign m_axis_tlast = head.line_last;

endmodule

`default_nettype wire

// ----- src/a2pp_palette.sv -----
`timescale 1ns / 1ps
`default_nettype none

module a2pp_palette #(
    parameter int ENTRIES = 256
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  wire logic [31:0]                wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic      [31:0]                rd_data
);

    logic [31:0] mem [ENTRIES];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/a2pp_pack.sv -----
`timescale 1ns / 1ps
`default_nettype none

module a2pp_pack (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_load,
    input  wire a2pp_pkg::item_t in_item,
    output logic                 in_ready,
    input  wire logic [31:0]     palette_data,
    input  wire logic [2:0]      out_format,
    input  wire logic            source_indexed,
    input  wire logic            out_space,
    output a2pp_pkg::push_t      push
);

    import a2pp_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    item_t       s1_item_reg;
    logic [23:0] pend_bytes_reg;
    logic [23:0] pend_bytes_next;
    logic [1:0]  pend_count_reg;
    logic [1:0]  pend_count_next;

    logic        advance;
    logic        convert;
    logic [31:0] pix;
    logic [31:0] bytes;
    logic [2:0]  nbytes;
    logic [55:0] acc;
    logic [2:0]  total;
    logic        full;
    logic [23:0] rem;
    logic [2:0]  rem_count;
    logic        flush;

    assign advance  = s1_valid_reg && out_space;
    assign in_ready = !s1_valid_reg || out_space;
    assign convert  = advance && (s1_item_reg.cmd == CMD_CONVERT);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            s1_item_reg <= in_item;
        end
    end

    // Source color: palette entry or direct ARGB
    always_comb
    begin
        if (source_indexed)
        begin
            pix = s1_item_reg.index_in_range ? palette_data : 32'd0;
        end
        else
        begin
            pix = s1_item_reg.pixel_value;
        end
    end

    always_comb
    begin
        case (out_format)
            FMT_RGB555:
            begin
                bytes  = {17'd0, pix[23:19], pix[15:11], pix[7:3]};
                nbytes = 3'd2;
            end
            FMT_RGB565:
            begin
                bytes  = {16'd0, pix[23:19], pix[15:10], pix[7:3]};
                nbytes = 3'd2;
            end
            FMT_RGB24:
            begin
                bytes  = {8'd0, pix[7:0], pix[15:8], pix[23:16]};
                nbytes = 3'd3;
            end
            FMT_BGR24:
            begin
                bytes  = {8'd0, pix[23:16], pix[15:8], pix[7:0]};
                nbytes = 3'd3;
            end
            default:
            begin
                bytes  = pix;
                nbytes = FULL_WORD_BYTES;
            end
        endcase
    end

    // Append the new bytes behind the pending ones
    always_comb
    begin
        acc       = {32'd0, pend_bytes_reg} | ({24'd0, bytes} << {pend_count_reg, 3'b000});
        total     = {1'b0, pend_count_reg} + nbytes;
        full      = total >= FULL_WORD_BYTES;
        rem       = full ? acc[55:32] : acc[23:0];
        rem_count = full ? total - FULL_WORD_BYTES : total;
        flush     = s1_item_reg.end_of_line && (rem_count != 3'd0);
    end

    always_comb
    begin
        push.first.output_word  = full ? acc[31:0] : {8'd0, rem};
        push.first.byte_count   = full ? FULL_WORD_BYTES : rem_count;
        push.first.line_last    = s1_item_reg.end_of_line && (!full || !flush);
        push.second.output_word = {8'd0, rem};
        push.second.byte_count  = rem_count;
        push.second.line_last   = 1'b1;
        if (!convert)
        begin
            push.count = 2'd0;
        end
        else
        begin
            push.count = 2'({1'b0, full} + {1'b0, flush});
        end
    end

    always_comb
    begin
        pend_bytes_next = pend_bytes_reg;
        pend_count_next = pend_count_reg;
        if (convert)
        begin
            pend_bytes_next = s1_item_reg.end_of_line ? 24'd0 : rem;
            pend_count_next = s1_item_reg.end_of_line ? 2'd0 : rem_count[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bytes_reg <= 24'd0;
            pend_count_reg <= 2'd0;
        end
        else
        begin
            pend_bytes_reg <= pend_bytes_next;
            pend_count_reg <= pend_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/a2pp_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module a2pp_out_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire a2pp_pkg::push_t push,
    output logic                 space,
    output logic                 valid,
    input  wire logic            ready,
    output a2pp_pkg::result_t    head
);

    import a2pp_pkg::*;

    result_t    slot_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign valid = count_reg != 3'd0;
    assign pop   = valid && ready;
    assign space = count_reg <= 3'd2;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/a2pp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module a2pp_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [a2pp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tlast
);

    import a2pp_pkg::*;

    // A stalled output transfer holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

    // Byte count is 1..4
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:32] != 3'd0) &&
            (m_axis_tdata[34:32] <= FULL_WORD_BYTES))
    else $error("byte count out of range");

    // A partial word only ends a line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[34:32] != FULL_WORD_BYTES) |-> m_axis_tlast)
    else $error("partial word without end of line");

    // Bytes beyond the count are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[34:32] == 3'd1 && m_axis_tdata[31:8] == 24'd0) ||
            (m_axis_tdata[34:32] == 3'd2 && m_axis_tdata[31:16] == 16'd0) ||
            (m_axis_tdata[34:32] == 3'd3 && m_axis_tdata[31:24] == 8'd0) ||
            (m_axis_tdata[34:32] == FULL_WORD_BYTES))
    else $error("unused bytes not zero");

endmodule

bind argb_to_packed_pixel_stream_unit a2pp_checker u_a2pp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/sv/tb_argb_to_packed_pixel_stream_unit.sv -----
`timescale 1ns / 1ps

module tb_argb_to_packed_pixel_stream_unit;
    import a2pp_pkg::*;

    localparam int PALETTE_ENTRIES  = 256;
    localparam int RANDOM_ITEMS     = 900;
    // Margin past the pipeline; covers a load still in flight.
    localparam int SETTLE_CYCLES    = 4;
    localparam int HOLD_CYCLES      = 200;
    // Start the receiver hold-off with the first random phase past this count.
    localparam int HOLD_AFTER_ITEMS = 400;

    // Format codes with no meaning of their own; the block treats them as copy.
    localparam logic [2:0] FMT_SPARE_LO = 3'd5;
    localparam logic [2:0] FMT_SPARE_HI = 3'd7;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One line of stimulus: either an input transfer or a register write.
    typedef struct packed {
        row_kind_t   kind;
        logic        cmd;
        logic [7:0]  entry_index;
        logic [31:0] entry_color;
        logic [31:0] pixel_value;
        logic        end_of_line;
        logic        reg_index;
        logic [2:0]  reg_value;
        logic        fixed;       // expectation typed into the row
        logic        fixed_word;  // the row expects exactly one word
        result_t     word;
    } stim_row_t;

    // DUT ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = 1'b0;
    logic [2:0]           cfg_data = '0;

    // Shadow of the block's state, advanced on every accepted transfer
    logic [31:0] palette_shadow [PALETTE_ENTRIES];
    logic        palette_loaded [PALETTE_ENTRIES];
    logic [7:0]  loaded_slots [$];
    logic [23:0] held_bytes = '0;
    logic [1:0]  held_count = '0;
    logic [2:0]  format_shadow = FMT_COPY32;
    logic        indexed_shadow = 1'b0;

    result_t     pending_words [$];
    stim_row_t   directed_rows [$];
    result_t     want;

    int          fail_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    bit          hold_go = 1'b0;
    logic        rx_hold = 1'b0;

    argb_to_packed_pixel_stream_unit #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Row builders for the directed table
    function automatic stim_row_t pixel_row(input logic [31:0] pixel, input logic eol);
        stim_row_t r;
        r = '0;
        r.kind        = ROW_ITEM;
        r.cmd         = CMD_CONVERT;
        r.pixel_value = pixel;
        r.end_of_line = eol;
        return r;
    endfunction

    function automatic stim_row_t pixel_row_fixed(input logic [31:0] pixel, input logic eol,
                                                  input logic has_word, input logic [31:0] word,
                                                  input logic [2:0] count, input logic last);
        stim_row_t r;
        r = pixel_row(pixel, eol);
        r.fixed      = 1'b1;
        r.fixed_word = has_word;
        r.word       = '{word, count, last};
        return r;
    endfunction

    function automatic stim_row_t load_row(input logic [7:0] slot, input logic [31:0] color);
        stim_row_t r;
        r = '0;
        r.kind        = ROW_ITEM;
        r.cmd         = CMD_LOAD;
        r.entry_index = slot;
        r.entry_color = color;
        r.fixed       = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic idx, input logic [2:0] value);
        stim_row_t r;
        r = '0;
        r.kind      = ROW_CFG;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    // Convert one source pixel and pack its bytes behind the held ones.
    // Return up to two finished words and advance the shadow state.
    task automatic pack_pixel(input stim_row_t row, output int n,
                              output result_t w0, output result_t w1);
        logic [31:0] argb;
        logic [31:0] pix_bytes;
        logic [63:0] acc;
        result_t     flush;
        int          nbytes;
        int          total;
        n  = 0;
        w0 = '0;
        w1 = '0;
        if (row.cmd == CMD_LOAD)
        begin
            // Load: write the slot, leave the held bytes alone
            palette_shadow[row.entry_index] = row.entry_color;
            if (!palette_loaded[row.entry_index])
            begin
                palette_loaded[row.entry_index] = 1'b1;
                loaded_slots.push_back(row.entry_index);
            end
            return;
        end
        argb = indexed_shadow ? palette_shadow[row.pixel_value[7:0]] : row.pixel_value;
        case (format_shadow)
            FMT_RGB555:
            begin
                pix_bytes = {17'd0, argb[23:19], argb[15:11], argb[7:3]};
                nbytes    = 2;
            end
            FMT_RGB565:
            begin
                pix_bytes = {16'd0, argb[23:19], argb[15:10], argb[7:3]};
                nbytes    = 2;
            end
            FMT_RGB24:
            begin
                pix_bytes = {8'd0, argb[7:0], argb[15:8], argb[23:16]};
                nbytes    = 3;
            end
            FMT_BGR24:
            begin
                pix_bytes = {8'd0, argb[23:0]};
                nbytes    = 3;
            end
            default:
            begin
                pix_bytes = argb;
                nbytes    = 4;
            end
        endcase
        acc   = {40'd0, held_bytes} | ({32'd0, pix_bytes} << (8 * held_count));
        total = held_count + nbytes;
        if (total >= 4)
        begin
            // A full word closes the line only if nothing is left over
            w0    = '{acc[31:0], FULL_WORD_BYTES, row.end_of_line && total == 4};
            n     = 1;
            acc   = acc >> 32;
            total = total - 4;
        end
        if (row.end_of_line && total > 0)
        begin
            flush = '{acc[31:0], total[2:0], 1'b1};
            if (n == 0)
                w0 = flush;
            else
                w1 = flush;
            n     = n + 1;
            acc   = '0;
            total = 0;
        end
        held_bytes = acc[23:0];
        held_count = total[1:0];
    endtask

    // Offer one input transfer, honoring the burst and gap pattern, and record
    // what it must produce once it is accepted.
    task automatic send_item(input stim_row_t row);
        int      n;
        int      gap;
        result_t w0;
        result_t w1;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.pixel_value, row.entry_color, row.entry_index};
        s_axis_tlast  <= row.end_of_line;
        s_axis_tuser  <= row.cmd;
        do @(posedge clk); while (!s_axis_tready);
        pack_pixel(row, n, w0, w1);
        if (row.fixed)
        begin
            if (row.fixed_word)
                pending_words.push_back(row.word);
        end
        else
        begin
            if (n > 0)
                pending_words.push_back(w0);
            if (n > 1)
                pending_words.push_back(w1);
        end
    endtask

    // Wait for every expected word, then let the pipeline settle.
    task automatic wait_idle();
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register with the block idle; held bytes survive the write.
    task automatic write_reg(input logic idx, input logic [2:0] value);
        s_axis_tvalid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_OUT_FORMAT)
            format_shadow = value;
        else
            indexed_shadow = value[0];
    endtask

    // Compare every output transfer with the oldest expected word.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word: actual data=%h last=%b",
                         $realtime, m_axis_tdata, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_axis_tdata[31:0] !== want.output_word
                        || m_axis_tdata[34:32] !== want.byte_count
                        || m_axis_tlast !== want.line_last
                        || m_axis_tdata[M_TDATA_W-1:35] !== '0)
                begin
                    $display({"%0t: mismatch: expected word=%h count=%0d last=%b, ",
                              "actual word=%h count=%0d last=%b fill=%h"},
                             $realtime, want.output_word, want.byte_count, want.line_last,
                             m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast,
                             m_axis_tdata[M_TDATA_W-1:35]);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: switch between always ready, coin flips, a sparse periodic ready
    // and mostly ready, each for a random stretch. The hold-off overrides all.
    initial
    begin
        int  mode;
        int  stretch;
        int  tick;
        bit  ready;
        mode    = 0;
        stretch = 0;
        tick    = 0;
        forever
        begin
            @(posedge clk);
            if (stretch == 0)
            begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(20, 300);
            end
            stretch--;
            tick++;
            case (mode)
                0:       ready = 1'b1;
                1:       ready = $urandom_range(0, 1);
                2:       ready = (tick % 4 == 0);
                default: ready = ($urandom_range(0, 4) != 0);
            endcase
            m_axis_tready <= ready && !rx_hold;
        end
    end

    // Hold off the receiver for a long stretch at the start of a random phase
    // so the output queue fills and the input stalls while items keep coming.
    initial
    begin
        wait (hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL argb_to_packed_pixel_stream_unit");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        int        sent;
        int        phase_len;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            palette_shadow[i] = '0;
            palette_loaded[i] = 1'b0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Copy mode straight out of reset; exact word ends close the line
        directed_rows.push_back(pixel_row_fixed(32'hFFFF_FFFF, 1'b0,
                                                1'b1, 32'hFFFF_FFFF, 3'd4, 1'b0));
        directed_rows.push_back(pixel_row_fixed(32'h0000_0000, 1'b1,
                                                1'b1, 32'h0000_0000, 3'd4, 1'b1));
        directed_rows.push_back(pixel_row_fixed(32'h1234_5678, 1'b1,
                                                1'b1, 32'h1234_5678, 3'd4, 1'b1));
        // 15-bit: short line flushes two bytes, then two pixels fill a word
        directed_rows.push_back(reg_row(CFG_OUT_FORMAT, FMT_RGB555));
        directed_rows.push_back(pixel_row_fixed(32'h00FF_FFFF, 1'b1,
                                                1'b1, 32'h0000_7FFF, 3'd2, 1'b1));
        directed_rows.push_back(pixel_row_fixed(32'hFF00_0000, 1'b0,
                                                1'b0, 32'h0, 3'd0, 1'b0));
        directed_rows.push_back(pixel_row_fixed(32'h00F8_F8F8, 1'b0,
                                                1'b1, 32'h7FFF_0000, 3'd4, 1'b0));
        // 16-bit: truncated low bits drop to zero
        directed_rows.push_back(reg_row(CFG_OUT_FORMAT, FMT_RGB565));
        directed_rows.push_back(pixel_row_fixed(32'h00FF_FFFF, 1'b0,
                                                1'b0, 32'h0, 3'd0, 1'b0));
        directed_rows.push_back(pixel_row_fixed(32'h0007_0307, 1'b1,
                                                1'b1, 32'h0000_FFFF, 3'd4, 1'b1));
        // 24-bit in both byte orders, with words straddling pixels
        directed_rows.push_back(reg_row(CFG_OUT_FORMAT, FMT_RGB24));
        directed_rows.push_back(pixel_row_fixed(32'h0011_2233, 1'b1,
                                                1'b1, 32'h0033_2211, 3'd3, 1'b1));
        directed_rows.push_back(pixel_row(32'hAABB_CCDD, 1'b0));
        directed_rows.push_back(pixel_row(32'h0102_0304, 1'b0));
        directed_rows.push_back(pixel_row(32'h8040_2010, 1'b1));
        directed_rows.push_back(reg_row(CFG_OUT_FORMAT, FMT_BGR24));
        directed_rows.push_back(pixel_row_fixed(32'hFF11_2233, 1'b1,
                                                1'b1, 32'h0011_2233, 3'd3, 1'b1));
        // Change format mid-line: three bytes stay held across the write
        directed_rows.push_back(pixel_row(32'h00C0_FFEE, 1'b0));
        directed_rows.push_back(reg_row(CFG_OUT_FORMAT, FMT_RGB555));
        directed_rows.push_back(pixel_row(32'h007F_3F1F, 1'b1));
        // Palette: edge slots and alternating bit patterns, then indexed lookups
        directed_rows.push_back(load_row(8'h00, 32'h00FF_FFFF));
        directed_rows.push_back(load_row(8'hFF, 32'hFFFF_FFFF));
        directed_rows.push_back(load_row(8'hAA, 32'h5A5A_A5A5));
        directed_rows.push_back(load_row(8'h55, 32'hA5A5_5A5A));
        directed_rows.push_back(reg_row(CFG_OUT_FORMAT, FMT_BGR24));
        directed_rows.push_back(reg_row(CFG_SOURCE_INDEXED, 3'd1));
        directed_rows.push_back(pixel_row_fixed(32'hFFFF_FF00, 1'b1,
                                                1'b1, 32'h00FF_FFFF, 3'd3, 1'b1));
        directed_rows.push_back(pixel_row(32'h0000_00FF, 1'b0));
        directed_rows.push_back(pixel_row(32'h0000_00AA, 1'b0));
        directed_rows.push_back(pixel_row(32'h0000_0055, 1'b1));
        // Spare format codes fall back to the 32-bit copy
        directed_rows.push_back(reg_row(CFG_OUT_FORMAT, FMT_SPARE_HI));
        directed_rows.push_back(pixel_row_fixed(32'h0000_00FF, 1'b1,
                                                1'b1, 32'hFFFF_FFFF, 3'd4, 1'b1));
        directed_rows.push_back(reg_row(CFG_OUT_FORMAT, FMT_SPARE_LO));
        directed_rows.push_back(pixel_row_fixed(32'h0000_0000, 1'b0,
                                                1'b1, 32'h00FF_FFFF, 3'd4, 1'b0));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                send_item(directed_rows[i]);
        end

        // Random phases: new settings, then a run of lines with random content
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_reg(CFG_OUT_FORMAT, 3'($urandom_range(0, 7)));
            write_reg(CFG_SOURCE_INDEXED, 3'($urandom_range(0, 1)));
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(30, 90);
            if (!hold_go && sent >= HOLD_AFTER_ITEMS)
                hold_go = 1'b1;
            repeat (phase_len)
            begin
                row = '0;
                row.kind        = ROW_ITEM;
                row.entry_index = 8'($urandom);
                row.entry_color = $urandom;
                row.pixel_value = $urandom;
                row.end_of_line = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 99) < 15)
                begin
                    row.cmd = CMD_LOAD;
                end
                else
                begin
                    row.cmd = CMD_CONVERT;
                    if (indexed_shadow)
                    begin
                        // Look up only slots that hold a color
                        row.pixel_value[7:0] =
                            loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
                    end
                    else
                    begin
                        case ($urandom_range(0, 15))
                            0:       row.pixel_value = 32'h0000_0000;
                            1:       row.pixel_value = 32'hFFFF_FFFF;
                            default: ;
                        endcase
                    end
                end
                send_item(row);
                sent++;
            end
        end

        // Drop valid, drain the output and let the pipeline run dry
        s_axis_tvalid <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("PASS argb_to_packed_pixel_stream_unit");
        else
            $display("FAIL argb_to_packed_pixel_stream_unit");
        $finish;
    end

endmodule
